// ----- hw/rtl/swmm_pkg.sv -----
// Shared types and constants of the sliding window min/max block.
// No dependencies; imported by swmm_cell, swmm_chain, sliding_window_min_max, swmm_extrema_checker and the testbench.
package swmm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int WSIZE_W  = 11;

    // Register index (byte address 4*index, index taken from paddr[2])
    localparam logic REG_WINDOW_SIZE = 1'b0;

    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 11'd1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Broadcast control shared by every cell of one chain
    typedef struct packed {
        logic accept;   // a sample is taken this cycle
        logic shift;    // every entry moves one cell toward the head
        logic clear;    // end of sequence: drop every entry
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/swmm_cell.sv -----
// One cell of a monotonic queue chain: holds one (value, age) entry.
// Depends on swmm_pkg.
module swmm_cell #(
    parameter int AGE_W    = 10,
    parameter bit KEEP_MAX = 1'b1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  swmm_pkg::cell_ctrl_t ctrl,
    input  swmm_pkg::sample_t    sample,
    input  logic                 up_valid,
    input  swmm_pkg::sample_t    up_value,
    input  logic [AGE_W-1:0]     up_age,
    input  logic                 prev_keep,
    output logic                 valid,
    output swmm_pkg::sample_t    value,
    output logic [AGE_W-1:0]     age,
    output logic                 keep
);
    import swmm_pkg::*;

    logic             valid_reg;
    sample_t          value_reg;
    logic [AGE_W-1:0] age_reg;

    logic             src_valid;
    sample_t          src_value;
    logic [AGE_W-1:0] src_age;
    logic             dominated;

    // Entry this cell sees after an optional head expiry shift
    always_comb begin
        src_valid = ctrl.shift ? up_valid : valid_reg;
        src_value = ctrl.shift ? up_value : value_reg;
        src_age   = ctrl.shift ? up_age   : age_reg;
        if (KEEP_MAX) begin
            dominated = (src_value <= sample);
        end else begin
            dominated = (src_value >= sample);
        end
        keep = src_valid && !dominated;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.clear) begin
            valid_reg <= 1'b0;
        end else if (ctrl.accept) begin
            valid_reg <= keep || prev_keep;
        end else if (ctrl.shift) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.accept) begin
            if (keep) begin
                value_reg <= src_value;
                age_reg   <= src_age + AGE_W'(1);
            end else begin
                // first free cell behind the kept run takes the new sample
                value_reg <= sample;
                age_reg   <= '0;
            end
        end else if (ctrl.shift) begin
            value_reg <= up_value;
            age_reg   <= up_age;
        end
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign age   = age_reg;

endmodule

// ----- hw/rtl/swmm_chain.sv -----
// Row of swmm_cell instances forming one monotonic queue, head in cell 0.
// Depends on swmm_pkg and swmm_cell.
module swmm_chain #(
    parameter int WINDOW_MAX = 1024,
    parameter bit KEEP_MAX   = 1'b1,
    parameter int WW         = 11
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic              last,
    input  swmm_pkg::sample_t sample,
    input  logic [WW-1:0]     w_eff,
    output logic              purge,
    output swmm_pkg::sample_t head_next
);
    import swmm_pkg::*;

    localparam int AGE_W = $clog2(WINDOW_MAX);

    logic             cell_valid [WINDOW_MAX];
    sample_t          cell_value [WINDOW_MAX];
    logic [AGE_W-1:0] cell_age   [WINDOW_MAX];
    logic             cell_keep  [WINDOW_MAX];

    cell_ctrl_t    ctrl;
    logic [WW-1:0] head_age;
    logic          expire;

    // Head ages are below w_eff after every accepted sample; a smaller
    // window set while idle leaves heads with age >= w_eff: purge them.
    assign head_age = WW'(cell_age[0]);
    assign purge    = cell_valid[0] && (head_age >= w_eff);
    assign expire   = cell_valid[0] && (head_age >= w_eff - WW'(1));

    always_comb begin
        ctrl.accept = accept;
        ctrl.shift  = accept ? expire : purge;
        ctrl.clear  = accept && last;
    end

    assign head_next = cell_keep[0] ? (expire ? cell_value[1] : cell_value[0]) : sample;

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        logic             up_valid;
        sample_t          up_value;
        logic [AGE_W-1:0] up_age;
        logic             prev_keep;

        if (i == WINDOW_MAX - 1) begin : g_end
            assign up_valid = 1'b0;
            assign up_value = '0;
            assign up_age   = '0;
        end else begin : g_mid
            assign up_valid = cell_valid[i+1];
            assign up_value = cell_value[i+1];
            assign up_age   = cell_age[i+1];
        end

        if (i == 0) begin : g_first
            assign prev_keep = 1'b1;
        end else begin : g_rest
            assign prev_keep = cell_keep[i-1];
        end

        swmm_cell #(
            .AGE_W    (AGE_W),
            .KEEP_MAX (KEEP_MAX)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .sample    (sample),
            .up_valid  (up_valid),
            .up_value  (up_value),
            .up_age    (up_age),
            .prev_keep (prev_keep),
            .valid     (cell_valid[i]),
            .value     (cell_value[i]),
            .age       (cell_age[i]),
            .keep      (cell_keep[i])
        );
    end

endmodule

// ----- hw/rtl/sliding_window_min_max.sv -----
// Top level of the sliding window min/max block: APB register, two cell chains, output stage.
// Depends on swmm_pkg and swmm_chain (which uses swmm_cell).
//
//  channel   direction  handshake              payload
//  s_        in         s_tvalid / s_tready    s_tdata = sample, s_tlast = last_sample
//  m_        out        m_tvalid / m_tready    m_tdata = {window_max, window_min}
//  apb       in         psel+penable, pready   window_size at byte address 0
//
// One sample per cycle while s_tready is high: both chains update all cells in the transaction's cycle and
// the result lands in the output register at the same edge.
// After window_size is lowered, each chain drops one stale head per cycle before
// the next sample is taken, and s_tready stays low until both chains are done.
// Reset empties both chains and sets window_size to 1; s_tlast empties them after use.
// A stalled m_ side holds the result; when it is taken, s_tready is high unless a chain purges.
module sliding_window_min_max #(
    parameter int WINDOW_MAX = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] sample
    input  logic        s_tlast,    // last_sample
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [31:0] window_min, [63:32] window_max
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import swmm_pkg::*;

    localparam int WW = (WSIZE_W > $clog2(WINDOW_MAX + 1)) ? WSIZE_W
                                                           : $clog2(WINDOW_MAX + 1);
    localparam int FW = $clog2(WINDOW_MAX + 1);

    logic [WSIZE_W-1:0] window_size_reg;
    logic [FW-1:0]      fill_reg, fill_next;
    logic               m_tvalid_reg;
    sample_t            min_reg, max_reg;

    logic [WW-1:0] w_wide;
    logic [WW-1:0] w_eff;
    logic          accept;
    logic          out_free;
    logic          result;
    logic          purge_max, purge_min;
    sample_t       sample;
    sample_t       head_max, head_min;

    // Configuration: setup then access cycle, no wait states
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? 32'(window_size_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= WSIZE_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_WINDOW_SIZE) begin
            window_size_reg <= pwdata[WSIZE_W-1:0];
        end
    end

    // Clamp the window to 1..WINDOW_MAX
    always_comb begin
        w_wide = WW'(window_size_reg);
        if (w_wide == '0) begin
            w_eff = WW'(1);
        end else if (w_wide > WW'(WINDOW_MAX)) begin
            w_eff = WW'(WINDOW_MAX);
        end else begin
            w_eff = w_wide;
        end
    end

    // Hold input while either chain purges or a result is stuck downstream
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = out_free && !purge_max && !purge_min;
    assign accept   = s_tvalid && s_tready;
    assign sample   = sample_t'(s_tdata);

    swmm_chain #(
        .WINDOW_MAX (WINDOW_MAX),
        .KEEP_MAX   (1'b1),
        .WW         (WW)
    ) u_max_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .last      (s_tlast),
        .sample    (sample),
        .w_eff     (w_eff),
        .purge     (purge_max),
        .head_next (head_max)
    );

    swmm_chain #(
        .WINDOW_MAX (WINDOW_MAX),
        .KEEP_MAX   (1'b0),
        .WW         (WW)
    ) u_min_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .last      (s_tlast),
        .sample    (sample),
        .w_eff     (w_eff),
        .purge     (purge_min),
        .head_next (head_min)
    );

    // Count samples of the sequence, saturating at WINDOW_MAX
    assign fill_next = (fill_reg == FW'(WINDOW_MAX)) ? fill_reg : fill_reg + FW'(1);
    assign result    = WW'(fill_next) >= w_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                fill_reg <= s_tlast ? '0 : fill_next;
            end
            if (accept) begin
                m_tvalid_reg <= result;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && result) begin
            min_reg <= head_min;
            max_reg <= head_max;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {max_reg, min_reg};

endmodule

// ----- verif/swmm_extrema_checker.sv -----
`timescale 1ns / 100ps
// Result checker for sliding_window_min_max: follows window_size writes on the APB port,
// predicts the min/max of each sample transaction's window and compares the m_ stream.
// Depends on swmm_pkg.
module swmm_extrema_checker #(
    parameter int WINDOW_MAX = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] sample
    input  logic        s_tlast,    // last_sample
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,    // [31:0] window_min, [63:32] window_max
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        run_end,
    output int          outstanding,
    output int          fail_count
);
    import swmm_pkg::*;

    localparam int POS_W = $clog2(2 * WINDOW_MAX);

    typedef struct {
        sample_t          value;
        logic [POS_W-1:0] pos;
    } held_sample_t;

    typedef struct {
        sample_t lo;
        sample_t hi;
    } extrema_t;

    held_sample_t       max_deque[$];
    held_sample_t       min_deque[$];
    extrema_t           expected_extrema[$];
    logic [WSIZE_W-1:0] window_size;
    logic [POS_W-1:0]   next_pos;
    int                 seq_fill;
    bit                 end_checked;
    extrema_t           want;

    task automatic flag_mismatch(input string what);
        $display("%0t ns  mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // age is taken modulo the position range, as positions wrap
    function automatic bit aged_out(logic [POS_W-1:0] held_pos, int span);
        logic [POS_W-1:0] age;
        age = next_pos - held_pos;
        return int'(age) >= span;
    endfunction

    function automatic void slide_window(sample_t smp, logic closes_seq);
        int           span;
        held_sample_t entry;
        extrema_t     ext;
        if (window_size == '0)
            span = 1;
        else if (int'(window_size) > WINDOW_MAX)
            span = WINDOW_MAX;
        else
            span = int'(window_size);
        while (max_deque.size() > 0 && aged_out(max_deque[0].pos, span))
            void'(max_deque.pop_front());
        while (min_deque.size() > 0 && aged_out(min_deque[0].pos, span))
            void'(min_deque.pop_front());
        // drop dominated tails; ties go too
        while (max_deque.size() > 0 && max_deque[$].value <= smp)
            void'(max_deque.pop_back());
        while (min_deque.size() > 0 && min_deque[$].value >= smp)
            void'(min_deque.pop_back());
        entry.value = smp;
        entry.pos   = next_pos;
        max_deque.push_back(entry);
        min_deque.push_back(entry);
        if (seq_fill < WINDOW_MAX)
            seq_fill++;
        next_pos++;
        if (seq_fill >= span) begin
            ext.lo = min_deque[0].value;
            ext.hi = max_deque[0].value;
            expected_extrema.push_back(ext);
        end
        if (closes_seq) begin
            max_deque.delete();
            min_deque.delete();
            next_pos = '0;
            seq_fill = 0;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            max_deque.delete();
            min_deque.delete();
            expected_extrema.delete();
            window_size = WSIZE_RESET;
            next_pos    = '0;
            seq_fill    = 0;
        end else begin
            if (s_tvalid && s_tready)
                slide_window(sample_t'(s_tdata), s_tlast);
            if (psel && penable && pwrite && pready && paddr[2] == REG_WINDOW_SIZE)
                window_size = pwdata[WSIZE_W-1:0];
            if (m_tvalid && m_tready) begin
                if (expected_extrema.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result min %0d max %0d",
                                            sample_t'(m_tdata[31:0]),
                                            sample_t'(m_tdata[63:32])));
                end else begin
                    want = expected_extrema.pop_front();
                    if (sample_t'(m_tdata[31:0]) !== want.lo)
                        flag_mismatch($sformatf("window_min got %0d expected %0d",
                                                sample_t'(m_tdata[31:0]), want.lo));
                    if (sample_t'(m_tdata[63:32]) !== want.hi)
                        flag_mismatch($sformatf("window_max got %0d expected %0d",
                                                sample_t'(m_tdata[63:32]), want.hi));
                end
            end
            if (run_end && !end_checked) begin
                end_checked = 1'b1;
                if (expected_extrema.size() != 0)
                    flag_mismatch($sformatf("%0d results never arrived",
                                            expected_extrema.size()));
            end
        end
        // outstanding is assigned nonblocking, so the stimulus side never races the update
        outstanding <= expected_extrema.size();
    end

endmodule

// ----- verif/tb_sliding_window_min_max.sv -----
`timescale 1ns / 100ps
// Testbench top for sliding_window_min_max: clock, reset, APB writes, sample stimulus
// and result back-pressure. Depends on swmm_pkg, sliding_window_min_max and swmm_extrema_checker.
module tb_sliding_window_min_max;
    import swmm_pkg::*;

    localparam int         WINDOW_MAX        = 1024;
    localparam logic [2:0] WSIZE_ADDR        = {REG_WINDOW_SIZE, 2'b00};
    localparam logic [2:0] SPARE_ADDR        = 3'h4;   // no register decodes here
    localparam int         LATENCY_SLACK     = 4;
    localparam int         SMALL_PHASE_ITEMS = 230;

    // back-pressure patterns of the result side
    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;     // [31:0] sample
    logic        s_tlast  = 1'b0;   // last_sample
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;           // [31:0] window_min, [63:32] window_max
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        run_end  = 1'b0;

    int          outstanding;
    int          fail_count;
    int          burst_left;
    int          rx_left;
    rx_pattern_t rx_pattern;
    sample_t     walk_value = '0;

    sliding_window_min_max #(
        .WINDOW_MAX(WINDOW_MAX)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    swmm_extrema_checker #(
        .WINDOW_MAX(WINDOW_MAX)
    ) extrema_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .run_end    (run_end),
        .outstanding(outstanding),
        .fail_count (fail_count)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Result side: switch between open, lightly and heavily stalled and periodic
    // stretches, each of random length, so stalls land on every phase of the work.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_pattern = rx_pattern_t'($urandom_range(0, 3));
            rx_left    = $urandom_range(16, 160);
        end else begin
            rx_left--;
        end
        case (rx_pattern)
            RX_OPEN:  m_tready <= 1'b1;
            RX_LIGHT: m_tready <= ($urandom_range(0, 7) != 0);
            RX_HEAVY: m_tready <= ($urandom_range(0, 2) == 0);
            default:  m_tready <= (rx_left % 4 != 0);
        endcase
    end

    // Setup cycle, then access cycle; the write lands at the edge where pready is seen.
    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offer one sample transaction. Bursts keep tvalid high back to back; a gap with
    // tvalid low separates bursts, so tvalid never drops and rises in one step.
    task automatic push_sample(input sample_t smp, input logic closes);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= closes;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    // Hold the sender until every expected result is in, then wait out LATENCY_SLACK
    // for a sample that produced no result.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (LATENCY_SLACK) @(posedge aclk);
    endtask

    // Mix full-range values, a narrow band full of ties, the extremes and a slow walk
    // that builds monotonic runs.
    function automatic sample_t draw_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return sample_t'($urandom);
            4, 5:       return sample_t'($urandom_range(0, 6)) - 3;
            6:          return $urandom_range(0, 1) ? sample_t'(32'h7FFF_FFFF)
                                                    : sample_t'(32'h8000_0000);
            default: begin
                walk_value = walk_value + sample_t'($urandom_range(0, 4)) - 2;
                return walk_value;
            end
        endcase
    endfunction

    // seq_hint is the mean sequence length; zero keeps the sequence open
    task automatic run_stream(input int count, input int seq_hint, input bit close_at_end);
        bit closes;
        for (int i = 0; i < count; i++) begin
            closes = (seq_hint > 0 && $urandom_range(1, seq_hint) == 1) ||
                     (close_at_end && i == count - 1);
            push_sample(draw_sample(), closes);
        end
    endtask

    initial begin
        int span;
        int sent;
        int count;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Window of one after reset: each sample is its own min and max.
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h0000_0000, 1'b0);
        push_sample(32'hFFFF_FFFF, 1'b1);
        settle();

        // Window of three: equal values, then both extremes back to back.
        write_register(WSIZE_ADDR, 32'd3);
        push_sample(5, 1'b0);
        push_sample(5, 1'b0);
        push_sample(5, 1'b0);
        push_sample(-3, 1'b0);
        push_sample(32'h8000_0000, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(32'h7FFF_FFFF, 1'b0);
        push_sample(2, 1'b1);
        settle();

        // Sequence shorter than the window: no result, but the last flag still clears.
        write_register(WSIZE_ADDR, 32'd4);
        push_sample(1, 1'b0);
        push_sample(2, 1'b1);
        settle();

        // Change the window in the middle of a sequence, up and then down. The write
        // to the unmapped address must leave the window at five.
        write_register(WSIZE_ADDR, 32'd2);
        push_sample(10, 1'b0);
        push_sample(20, 1'b0);
        push_sample(30, 1'b0);
        settle();
        write_register(WSIZE_ADDR, 32'd5);
        write_register(SPARE_ADDR, 32'd1);
        push_sample(40, 1'b0);
        push_sample(25, 1'b0);
        settle();
        write_register(WSIZE_ADDR, 32'd1);
        push_sample(-7, 1'b1);
        settle();

        // One long sequence: the largest window, values above the limit that saturate,
        // zero that counts as one (a long purge of stale heads), then a small window.
        write_register(WSIZE_ADDR, WINDOW_MAX);
        run_stream(1030, 0, 1'b0);
        settle();
        write_register(WSIZE_ADDR, 32'd2047);
        run_stream(10, 0, 1'b0);
        settle();
        write_register(WSIZE_ADDR, WINDOW_MAX + 1);
        run_stream(10, 0, 1'b0);
        settle();
        write_register(WSIZE_ADDR, 32'd0);
        run_stream(20, 0, 1'b0);
        settle();
        write_register(WSIZE_ADDR, 32'd6);
        run_stream(100, 0, 1'b1);

        // Random phases with small windows; sequences mostly longer than the window,
        // and a phase often ends mid-sequence so the next window applies to held state.
        sent = 0;
        while (sent < SMALL_PHASE_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       span = 1;
                1:       span = 2;
                2:       span = $urandom_range(3, 8);
                3:       span = $urandom_range(9, 40);
                4:       span = $urandom_range(41, 150);
                default: span = $urandom_range(3, 16);
            endcase
            settle();
            if ($urandom_range(0, 7) == 0)
                write_register(SPARE_ADDR, $urandom);
            write_register(WSIZE_ADDR, span);
            count = $urandom_range(30, 120);
            run_stream(count, span * $urandom_range(1, 4) + $urandom_range(0, 3),
                       $urandom_range(0, 3) != 0);
            sent += count;
        end

        // Drain, let the pipeline go quiet, then collect the verdict.
        settle();
        repeat (16) @(posedge aclk);
        run_end <= 1'b1;
        repeat (2) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_sliding_window_min_max OK");
        else
            $display("tb_sliding_window_min_max NOT OK");
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("tb_sliding_window_min_max NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/swmm_pkg.sv
hw/rtl/swmm_cell.sv
hw/rtl/swmm_chain.sv
hw/rtl/sliding_window_min_max.sv
verif/swmm_extrema_checker.sv
verif/tb_sliding_window_min_max.sv
